/* rtl/core/first_fit_heap_allocator_defines.svh */
// Assertion macros for the allocator core.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FFHA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFHA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ffha_pkg.sv */
package ffha_pkg;

	localparam int ARENA_BYTES  = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int OFF_W        = 12;
	localparam int SIZE_W       = 13;
	localparam int SUM_W        = 14;
	localparam int HDR_W        = 28;

	// Command codes on the request channel
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic              free_mark;
		logic              end_mark;
		logic              start;
		logic [OFF_W-1:0]  prev;
	} hdr_t;

	localparam hdr_t INIT_HDR = '{
		size: SIZE_W'(ARENA_BYTES), free_mark: 1'b1, end_mark: 1'b1,
		start: 1'b1, prev: '0};

endpackage

/* rtl/core/ffha_if.sv */
// Request channel: one allocate or free command per transfer.
interface ffha_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [11:0] request_bytes;
	logic [11:0] block_offset;

	modport source (output valid, operation, request_bytes, block_offset, input ready);
	modport sink (input valid, operation, request_bytes, block_offset, output ready);
endinterface

// Response channel: one result per command.
interface ffha_rsp_if;
	logic        valid;
	logic        ready;
	logic [11:0] payload_offset;
	logic        success;

	modport source (output valid, payload_offset, success, input ready);
	modport sink (input valid, payload_offset, success, output ready);
endinterface

/* rtl/core/ffha_hdr_ram.sv */
// Single-port-write, single-port-read RAM with registered read data.
module ffha_hdr_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 28
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/first_fit_heap_allocator.sv */
// First-fit heap allocator over a 4096-byte arena with 16-byte boundary-tag
// headers, one header slot per byte offset held in a 4096 x 28 RAM. After
// reset a clearing pass writes every RAM entry, during which no request is
// taken. Each command then runs as a read-modify-write sequence on the single
// RAM after the request transfer: an allocate reads each block visited by the
// walk from offset 0, then writes the header back when it succeeds, first
// relinking the following block when a split leaves one to relink; a valid
// free writes back its header and merges any free neighbors, a rejected one
// ends without a write. The result then moves into the output register,
// which holds it while the next request is taken.
module first_fit_heap_allocator (
	input logic      clk,
	input logic      arst_n,
	ffha_req_if.sink   req,
	ffha_rsp_if.source rsp
);

	`include "first_fit_heap_allocator_defines.svh"

	localparam logic [3:0] ST_CLR    = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_A_RD   = 4'd2;
	localparam logic [3:0] ST_A_CHK  = 4'd3;
	localparam logic [3:0] ST_A_HWR  = 4'd4;
	localparam logic [3:0] ST_F_RD   = 4'd5;
	localparam logic [3:0] ST_F_CHK  = 4'd6;
	localparam logic [3:0] ST_FN_RD  = 4'd7;
	localparam logic [3:0] ST_FN_CHK = 4'd8;
	localparam logic [3:0] ST_F_HWR  = 4'd9;
	localparam logic [3:0] ST_FP_RD  = 4'd10;
	localparam logic [3:0] ST_FP_CHK = 4'd11;
	localparam logic [3:0] ST_F_H3WR = 4'd12;
	localparam logic [3:0] ST_LNK_RD = 4'd13;
	localparam logic [3:0] ST_LNK_WR = 4'd14;
	localparam logic [3:0] ST_FIN    = 4'd15;

	localparam int OW = ffha_pkg::OFF_W;
	localparam int SW = ffha_pkg::SIZE_W;
	localparam int UW = ffha_pkg::SUM_W;

	logic [3:0]    state_q;
	logic [OW-1:0] clr_q;
	logic [OW-1:0] pos_q;
	logic [SW-1:0] need_q;
	ffha_pkg::hdr_t h_q;
	logic [OW-1:0] lnk_addr_q;
	logic [OW-1:0] lnk_prev_q;
	logic [3:0]    lnk_ret_q;
	logic          lnk_go_q;
	logic [OW-1:0] res_off_q;
	logic          res_ok_q;
	logic          out_valid_q;
	logic [OW-1:0] out_off_q;
	logic          out_ok_q;

	logic          wr_en;
	logic [OW-1:0] wr_addr;
	ffha_pkg::hdr_t wr_hdr;
	logic          rd_en;
	logic [OW-1:0] rd_addr;
	logic [ffha_pkg::HDR_W-1:0] rd_raw;
	ffha_pkg::hdr_t rd_hdr;

	// Sums and differences used for bounds checks and new block sizes
	logic [UW-1:0] pos_plus_rsize;
	logic [UW-1:0] pos_plus_need;
	logic [SW-1:0] rem;
	logic [UW-1:0] pos_plus_hsize;
	logic [SW-1:0] merged_size;
	logic [SW-1:0] pmerged_size;
	logic [UW-1:0] prev_plus_pms;
	logic          load_out;

	// Decisions and updated headers
	logic           fit;
	logic           split_ok;
	logic           relink_ok;
	ffha_pkg::hdr_t alloc_hdr;
	ffha_pkg::hdr_t freed_hdr;
	ffha_pkg::hdr_t merge_hdr;
	ffha_pkg::hdr_t unlinked_hdr;

	assign rd_hdr         = ffha_pkg::hdr_t'(rd_raw);
	assign pos_plus_rsize = UW'(pos_q) + UW'(rd_hdr.size);
	assign pos_plus_need  = UW'(pos_q) + UW'(need_q);
	assign rem            = rd_hdr.size - need_q;
	assign pos_plus_hsize = UW'(pos_q) + UW'(h_q.size);
	assign merged_size    = h_q.size + rd_hdr.size;
	assign pmerged_size   = rd_hdr.size + h_q.size;
	assign prev_plus_pms  = UW'(h_q.prev) + UW'(pmerged_size);
	assign load_out       = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);

	assign req.ready          = (state_q == ST_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.payload_offset = out_off_q;
	assign rsp.success        = out_ok_q;

	// Header updates for the current step
	always_comb begin
		fit       = rd_hdr.free_mark && (rd_hdr.size >= need_q);
		split_ok  = fit && (rem >= SW'(ffha_pkg::HEADER_BYTES)) &&
			(pos_plus_need < UW'(ffha_pkg::ARENA_BYTES));
		relink_ok = !rd_hdr.end_mark && (pos_plus_rsize < UW'(ffha_pkg::ARENA_BYTES));
		alloc_hdr           = rd_hdr;
		alloc_hdr.free_mark = 1'b0;
		if (split_ok) begin
			alloc_hdr.size     = need_q;
			alloc_hdr.end_mark = 1'b0;
		end
		freed_hdr           = rd_hdr;
		freed_hdr.free_mark = 1'b1;
		merge_hdr           = h_q;
		merge_hdr.size      = merged_size;
		merge_hdr.end_mark  = rd_hdr.end_mark;
		unlinked_hdr        = h_q;
		unlinked_hdr.start  = 1'b0;
	end

	// RAM port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_hdr  = h_q;
		rd_en   = 1'b0;
		rd_addr = pos_q;
		unique case (state_q)
			ST_CLR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_hdr  = (clr_q == '0) ? ffha_pkg::INIT_HDR : '0;
			end
			ST_A_RD, ST_F_RD: begin
				rd_en = 1'b1;
			end
			ST_A_CHK: begin
				// split: write the free remainder header
				wr_addr = pos_plus_need[OW-1:0];
				wr_hdr  = '{size: rem, free_mark: 1'b1, end_mark: rd_hdr.end_mark,
					start: 1'b1, prev: pos_q};
				wr_en   = split_ok;
			end
			ST_A_HWR, ST_F_HWR, ST_F_H3WR: begin
				wr_en = 1'b1;
			end
			ST_F_CHK: begin
				wr_hdr = freed_hdr;
				wr_en  = rd_hdr.start && !rd_hdr.free_mark;
			end
			ST_FN_RD: begin
				rd_en   = 1'b1;
				rd_addr = pos_plus_hsize[OW-1:0];
			end
			ST_FN_CHK: begin
				wr_addr      = pos_plus_hsize[OW-1:0];
				wr_hdr       = rd_hdr;
				wr_hdr.start = 1'b0;
				wr_en        = rd_hdr.free_mark;
			end
			ST_FP_RD: begin
				rd_en   = (pos_q != '0);
				rd_addr = h_q.prev;
			end
			ST_FP_CHK: begin
				wr_addr         = h_q.prev;
				wr_hdr          = rd_hdr;
				wr_hdr.size     = pmerged_size;
				wr_hdr.end_mark = h_q.end_mark;
				wr_en           = rd_hdr.free_mark;
			end
			ST_LNK_RD: begin
				rd_en   = 1'b1;
				rd_addr = lnk_addr_q;
			end
			ST_LNK_WR: begin
				wr_en       = 1'b1;
				wr_addr     = lnk_addr_q;
				wr_hdr      = rd_hdr;
				wr_hdr.prev = lnk_prev_q;
			end
			default: begin
			end
		endcase
	end

	ffha_hdr_ram #(
		.DEPTH(ffha_pkg::ARENA_BYTES),
		.AW(ffha_pkg::OFF_W),
		.DW(ffha_pkg::HDR_W)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_hdr),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	// Command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						res_ok_q  <= 1'b0;
						res_off_q <= '0;
						need_q    <= SW'(req.request_bytes) + SW'(ffha_pkg::HEADER_BYTES);
						if (req.operation == ffha_pkg::OP_FREE) begin
							if (req.block_offset < OW'(ffha_pkg::HEADER_BYTES)) begin
								state_q <= ST_FIN;
							end else begin
								pos_q   <= req.block_offset - OW'(ffha_pkg::HEADER_BYTES);
								state_q <= ST_F_RD;
							end
						end else begin
							pos_q   <= '0;
							state_q <= ST_A_RD;
						end
					end
				end
				ST_A_RD: state_q <= ST_A_CHK;
				ST_A_CHK: begin
					if (fit) begin
						res_ok_q   <= 1'b1;
						res_off_q  <= pos_q + OW'(ffha_pkg::HEADER_BYTES);
						h_q        <= alloc_hdr;
						lnk_addr_q <= pos_plus_rsize[OW-1:0];
						lnk_prev_q <= pos_plus_need[OW-1:0];
						lnk_ret_q  <= ST_A_HWR;
						// a split in front of another block relinks it first
						state_q    <= (split_ok && relink_ok) ? ST_LNK_RD : ST_A_HWR;
					end else if (rd_hdr.end_mark || (rd_hdr.size == '0) ||
						(pos_plus_rsize >= UW'(ffha_pkg::ARENA_BYTES))) begin
						state_q <= ST_FIN;
					end else begin
						pos_q   <= pos_plus_rsize[OW-1:0];
						state_q <= ST_A_RD;
					end
				end
				ST_A_HWR: state_q <= ST_FIN;
				ST_F_RD: state_q <= ST_F_CHK;
				ST_F_CHK: begin
					if (!rd_hdr.start || rd_hdr.free_mark) begin
						state_q <= ST_FIN;
					end else begin
						res_ok_q <= 1'b1;
						h_q      <= freed_hdr;
						state_q  <= relink_ok ? ST_FN_RD : ST_FP_RD;
					end
				end
				ST_FN_RD: state_q <= ST_FN_CHK;
				ST_FN_CHK: begin
					if (rd_hdr.free_mark) begin
						h_q     <= merge_hdr;
						state_q <= ST_F_HWR;
					end else begin
						state_q <= ST_FP_RD;
					end
				end
				ST_F_HWR: begin
					if (!h_q.end_mark && (pos_plus_hsize < UW'(ffha_pkg::ARENA_BYTES))) begin
						lnk_addr_q <= pos_plus_hsize[OW-1:0];
						lnk_prev_q <= pos_q;
						lnk_ret_q  <= ST_FP_RD;
						state_q    <= ST_LNK_RD;
					end else begin
						state_q <= ST_FP_RD;
					end
				end
				ST_FP_RD: begin
					state_q <= (pos_q == '0) ? ST_FIN : ST_FP_CHK;
				end
				ST_FP_CHK: begin
					if (rd_hdr.free_mark) begin
						h_q        <= unlinked_hdr;
						lnk_addr_q <= prev_plus_pms[OW-1:0];
						lnk_prev_q <= h_q.prev;
						lnk_ret_q  <= ST_FIN;
						lnk_go_q   <= !h_q.end_mark &&
							(prev_plus_pms < UW'(ffha_pkg::ARENA_BYTES));
						state_q    <= ST_F_H3WR;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_F_H3WR: state_q <= lnk_go_q ? ST_LNK_RD : ST_FIN;
				ST_LNK_RD: state_q <= ST_LNK_WR;
				ST_LNK_WR: state_q <= lnk_ret_q;
				ST_FIN: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
			out_off_q   <= res_off_q;
			out_ok_q    <= res_ok_q;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	`FFHA_ASSERT_IMP(a_no_req_in_clear, state_q == ST_CLR, !req.ready, "request taken during clear")
	`FFHA_ASSERT_IMP(a_no_rw_clash, wr_en && rd_en, wr_addr != rd_addr, "RAM read/write clash")
	`FFHA_ASSERT_NXT(a_result_loaded, load_out, out_valid_q, "result not loaded")
	`FFHA_ASSERT_NXT(a_req_starts_work, req.valid && req.ready, state_q != ST_IDLE, "request lost")

endmodule
